// ===== sv/gcb_pkg.sv =====
package gcb_pkg;

    localparam int MAX_X_DEF = 128;
    localparam int MAX_Y_DEF = 128;

    localparam int COORD_W = 7;
    localparam int CFG_W   = 8;
    localparam int COUNT_W = 15;
    localparam int CLASS_W = 3;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [CFG_W-1:0]   DIM_RESET = 8'd128;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

    localparam logic CMD_MARK     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [CLASS_W-1:0] {
        CLS_SOLID_INTERIOR = 3'd0,
        CLS_SOLID_BOUNDARY = 3'd1,
        CLS_PORE_BOUNDARY  = 3'd2,
        CLS_OPEN_PORE      = 3'd3,
        CLS_ENCLOSED_PORE  = 3'd4
    } node_class_t;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } grid_cfg_t;

endpackage

// ===== sv/grid_cell_boundary_classifier.sv =====
// Classify: three column reads from the single-port grid RAM (center, left,
// right), then the decision; the result waits while the output is stalled.
// In-grid mark: no result (read, then write back if the cell was not solid).
// Bad coordinate: a result with m_tuser set. Each item is done before s_tready rises again.
// Reset: synchronous, active low; then a clearing pass over all MAX_X columns, one
// column per cycle, with s_tready low; config writes are taken throughout.
module grid_cell_boundary_classifier #(
    parameter int MAX_X = gcb_pkg::MAX_X_DEF,
    parameter int MAX_Y = gcb_pkg::MAX_Y_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [gcb_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gcb_pkg::S_TDATA_W-1:0]   s_tdata,   // cell_x[6:0], cell_y[13:7]
    input  logic                            s_tuser,   // command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gcb_pkg::M_TDATA_W-1:0]   m_tdata,   // node_class[2:0], solid_total[17:3]
    output logic                            m_tuser    // bad_coordinate
);

    localparam int AW = $clog2(MAX_X);

    gcb_pkg::grid_cfg_t cfg_reg;

    logic             ram_en;
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [MAX_Y-1:0] ram_wdata;
    logic [MAX_Y-1:0] ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width  <= gcb_pkg::DIM_RESET;
            cfg_reg.height <= gcb_pkg::DIM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                gcb_pkg::REG_GRID_WIDTH:  cfg_reg.width  <= cfg_wdata;
                gcb_pkg::REG_GRID_HEIGHT: cfg_reg.height <= cfg_wdata;
                default: ;
            endcase
        end
    end

    gcb_col_ram #(
        .DEPTH (MAX_X),
        .WIDTH (MAX_Y)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    gcb_seq #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .ram_en    (ram_en),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

endmodule

// ===== sv/gcb_col_ram.sv =====
module gcb_col_ram #(
    parameter int DEPTH = gcb_pkg::MAX_X_DEF,
    parameter int WIDTH = gcb_pkg::MAX_Y_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                ram_reg[addr] <= wdata;
            end else begin
                rdata_reg <= ram_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/gcb_seq.sv =====
module gcb_seq #(
    parameter int MAX_X = gcb_pkg::MAX_X_DEF,
    parameter int MAX_Y = gcb_pkg::MAX_Y_DEF,
    localparam int AW   = $clog2(MAX_X),
    localparam int YW   = $clog2(MAX_Y)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  gcb_pkg::grid_cfg_t              cfg,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gcb_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gcb_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    output logic                            ram_en,
    output logic                            ram_we,
    output logic [AW-1:0]                   ram_addr,
    output logic [MAX_Y-1:0]                ram_wdata,
    input  logic [MAX_Y-1:0]                ram_rdata
);

    localparam int CW = gcb_pkg::COORD_W;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RDL,
        S_RDR,
        S_DEC,
        S_BAD
    } state_t;

    state_t                         state_reg;
    logic [AW-1:0]                  clr_cnt_reg;
    logic                           cmd_reg;
    logic [CW-1:0]                  x_reg;
    logic [CW-1:0]                  y_reg;
    logic [MAX_Y-1:0]               col_c_reg;
    logic [MAX_Y-1:0]               col_l_reg;
    logic [gcb_pkg::COUNT_W-1:0]    count_reg;
    logic                           m_tvalid_reg;
    gcb_pkg::node_class_t           m_class_reg;
    logic                           m_bad_reg;
    logic [gcb_pkg::COUNT_W-1:0]    m_total_reg;

    logic [CW-1:0]          in_x;
    logic [CW-1:0]          in_y;
    logic                   acc;
    logic                   in_ok;
    logic                   out_free;
    logic                   out_load;
    logic                   bit_here_rd;
    logic                   l_ok, r_ok, u_ok, d_ok;
    logic [7:0]             nb_mask;
    logic [7:0]             nb_bits;
    logic                   here;
    logic [3:0]             near;
    logic [3:0]             near_solid;
    gcb_pkg::node_class_t   cls;

    function automatic logic x_in(input logic [CW:0] v, input logic [gcb_pkg::CFG_W-1:0] lim);
        return (v < (CW+1)'(lim)) && (32'(v) < MAX_X);
    endfunction

    function automatic logic y_in(input logic [CW:0] v, input logic [gcb_pkg::CFG_W-1:0] lim);
        return (v < (CW+1)'(lim)) && (32'(v) < MAX_Y);
    endfunction

    assign in_x     = s_tdata[CW-1:0];
    assign in_y     = s_tdata[2*CW-1:CW];
    assign s_tready = (state_reg == S_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign in_ok    = x_in({1'b0, in_x}, cfg.width) && y_in({1'b0, in_y}, cfg.height);
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = ((state_reg == S_DEC) || (state_reg == S_BAD)) && out_free;

    assign bit_here_rd = ram_rdata[YW'(y_reg)];

    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = AW'(x_reg);
        ram_wdata = ram_rdata | (MAX_Y'(1) << YW'(y_reg));
        case (state_reg)
            S_CLR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
            end
            S_IDLE: begin
                ram_en   = acc && in_ok;
                ram_addr = AW'(in_x);
            end
            S_RDL: begin
                if (cmd_reg == gcb_pkg::CMD_MARK) begin
                    ram_en = !bit_here_rd;
                    ram_we = 1'b1;
                end else begin
                    ram_en   = 1'b1;
                    ram_addr = AW'(x_reg - CW'(1));
                end
            end
            S_RDR: begin
                ram_en   = 1'b1;
                ram_addr = AW'({1'b0, x_reg} + (CW+1)'(1));
            end
            default: begin
                ram_en = 1'b0;
            end
        endcase
    end

    // neighbor order: left column up/mid/down, center up/down, right up/mid/down
    always_comb begin
        l_ok = (x_reg != '0);
        r_ok = x_in({1'b0, x_reg} + (CW+1)'(1), cfg.width);
        u_ok = (y_reg != '0);
        d_ok = y_in({1'b0, y_reg} + (CW+1)'(1), cfg.height);

        nb_mask = {l_ok & u_ok, l_ok, l_ok & d_ok, u_ok, d_ok,
                   r_ok & u_ok, r_ok, r_ok & d_ok};
        nb_bits = {col_l_reg[YW'(y_reg - CW'(1))], col_l_reg[YW'(y_reg)],
                   col_l_reg[YW'({1'b0, y_reg} + (CW+1)'(1))],
                   col_c_reg[YW'(y_reg - CW'(1))],
                   col_c_reg[YW'({1'b0, y_reg} + (CW+1)'(1))],
                   ram_rdata[YW'(y_reg - CW'(1))], ram_rdata[YW'(y_reg)],
                   ram_rdata[YW'({1'b0, y_reg} + (CW+1)'(1))]};

        here       = col_c_reg[YW'(y_reg)];
        near       = 4'($countones(nb_mask));
        near_solid = 4'($countones(nb_mask & nb_bits));

        if (here) begin
            cls = (near_solid == near) ? gcb_pkg::CLS_SOLID_INTERIOR
                                       : gcb_pkg::CLS_SOLID_BOUNDARY;
        end else if (near_solid == 4'd0) begin
            cls = gcb_pkg::CLS_OPEN_PORE;
        end else if (near_solid < near) begin
            cls = gcb_pkg::CLS_PORE_BOUNDARY;
        end else begin
            cls = gcb_pkg::CLS_ENCLOSED_PORE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_cnt_reg  <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR: begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(MAX_X - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        cmd_reg   <= s_tuser;
                        x_reg     <= in_x;
                        y_reg     <= in_y;
                        state_reg <= in_ok ? S_RDL : S_BAD;
                    end
                end
                S_RDL: begin
                    if (cmd_reg == gcb_pkg::CMD_MARK) begin
                        if (!bit_here_rd && (count_reg != gcb_pkg::COUNT_MAX)) begin
                            count_reg <= count_reg + gcb_pkg::COUNT_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end else begin
                        col_c_reg <= ram_rdata;
                        state_reg <= S_RDR;
                    end
                end
                S_RDR: begin
                    col_l_reg <= ram_rdata;
                    state_reg <= S_DEC;
                end
                S_DEC: begin
                    if (out_free) begin
                        m_class_reg  <= cls;
                        m_bad_reg    <= 1'b0;
                        m_total_reg  <= count_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                S_BAD: begin
                    if (out_free) begin
                        m_class_reg  <= gcb_pkg::CLS_SOLID_INTERIOR;
                        m_bad_reg    <= 1'b1;
                        m_total_reg  <= count_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_bad_reg;
    assign m_tdata  = {6'b0, m_total_reg, m_class_reg};

endmodule

// ===== sv/gcb_checker.sv =====
module gcb_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [gcb_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                            m_tuser
);

    // no input transaction at the start of the grid clearing pass
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("s_tready high right after reset");

    // one item at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    a_bad_class_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[2:0] == gcb_pkg::CLS_SOLID_INTERIOR)
        else $error("bad coordinate with nonzero class");

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= gcb_pkg::CLS_ENCLOSED_PORE)
        else $error("class code out of range");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind grid_cell_boundary_classifier gcb_checker u_gcb_checker (.*);

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_X         = gcb_pkg::MAX_X_DEF;
    localparam int GRID_Y         = gcb_pkg::MAX_Y_DEF;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        gcb_pkg::node_class_t        cls;
        logic                        bad;
        logic [gcb_pkg::COUNT_W-1:0] total;
    } grid_result_t;

    typedef enum logic {ROW_ITEM, ROW_RESIZE} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        logic         cmd;
        logic [6:0]   x;
        logic [6:0]   y;
        logic [7:0]   w;
        logic [7:0]   h;
        bit           typed;
        grid_result_t want;
    } plan_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [0:0]                    cfg_index;
    logic [gcb_pkg::CFG_W-1:0]     cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [gcb_pkg::S_TDATA_W-1:0] s_tdata;   // cell_x[6:0], cell_y[13:7]
    logic                          s_tuser;   // command
    logic                          m_tvalid;
    logic                          m_tready;
    logic [gcb_pkg::M_TDATA_W-1:0] m_tdata;   // node_class[2:0], solid_total[17:3]
    logic                          m_tuser;   // bad_coordinate

    grid_cell_boundary_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // shadow grid state
    bit                          cell_solid [GRID_X][GRID_Y];
    logic [gcb_pkg::COUNT_W-1:0] solid_tally;
    logic [gcb_pkg::CFG_W-1:0]   width_reg;
    logic [gcb_pkg::CFG_W-1:0]   height_reg;

    grid_result_t pending_results[$];
    plan_row_t    directed_plan[$];

    int  error_count;
    int  items_in;
    int  results_checked;
    int  sizes_used;
    int  class_seen [5];
    int  quiet_cycles;
    int  hold_asks;
    bit  calm;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic bit in_grid(int x, int y);
        int ew;
        int eh;
        ew = (width_reg > GRID_X) ? GRID_X : width_reg;
        eh = (height_reg > GRID_Y) ? GRID_Y : height_reg;
        return x >= 0 && y >= 0 && x < ew && y < eh;
    endfunction

    // updates the shadow grid; returns 1 when the item yields a result
    function automatic bit predict_cell(input logic cmd, input logic [6:0] x,
                                        input logic [6:0] y, output grid_result_t res);
        int  near;
        int  near_solid;
        bit  ok;
        ok = in_grid(x, y);
        res.cls = gcb_pkg::CLS_SOLID_INTERIOR;
        res.bad = !ok;
        if (cmd == gcb_pkg::CMD_MARK && ok) begin
            if (!cell_solid[x][y]) begin
                cell_solid[x][y] = 1'b1;
                if (solid_tally != gcb_pkg::COUNT_MAX)
                    solid_tally++;
            end
            return 1'b0;
        end
        if (cmd == gcb_pkg::CMD_CLASSIFY && ok) begin
            near = 0;
            near_solid = 0;
            for (int dx = -1; dx <= 1; dx++) begin
                for (int dy = -1; dy <= 1; dy++) begin
                    if ((dx != 0 || dy != 0) && in_grid(x + dx, y + dy)) begin
                        near++;
                        near_solid += cell_solid[x + dx][y + dy];
                    end
                end
            end
            if (cell_solid[x][y])
                res.cls = (near_solid == near) ? gcb_pkg::CLS_SOLID_INTERIOR
                                               : gcb_pkg::CLS_SOLID_BOUNDARY;
            else if (near_solid == 0)
                res.cls = gcb_pkg::CLS_OPEN_PORE;
            else if (near_solid < near)
                res.cls = gcb_pkg::CLS_PORE_BOUNDARY;
            else
                res.cls = gcb_pkg::CLS_ENCLOSED_PORE;
        end
        res.total = solid_tally;
        return 1'b1;
    endfunction

    function automatic void plan_resize(logic [7:0] w, logic [7:0] h);
        plan_row_t row;
        row = '{ROW_RESIZE, gcb_pkg::CMD_MARK, 7'd0, 7'd0, w, h, 1'b0, '0};
        directed_plan = {directed_plan, row};
    endfunction

    function automatic void plan_item(logic cmd, logic [6:0] x, logic [6:0] y);
        plan_row_t row;
        row = '{ROW_ITEM, cmd, x, y, 8'd0, 8'd0, 1'b0, '0};
        directed_plan = {directed_plan, row};
    endfunction

    function automatic void plan_check(logic cmd, logic [6:0] x, logic [6:0] y,
                                       gcb_pkg::node_class_t cls, logic bad,
                                       logic [gcb_pkg::COUNT_W-1:0] total);
        plan_row_t row;
        row = '{ROW_ITEM, cmd, x, y, 8'd0, 8'd0, 1'b1, '{cls, bad, total}};
        directed_plan = {directed_plan, row};
    endfunction

    // called when aclk has just risen
    task automatic offer_item(input logic cmd, input logic [6:0] x, input logic [6:0] y,
                              input bit typed, input grid_result_t typed_res);
        grid_result_t res;
        int           gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, y, x};
        do
            @(posedge aclk);
        while (!s_tready);
        items_in++;
        if (predict_cell(cmd, x, y, res)) begin
            if (typed)
                res = typed_res;
            pending_results = {pending_results, res};
        end
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        // in-grid marks give no result and may still be writing back
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic resize_grid(input logic [7:0] w, input logic [7:0] h);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= gcb_pkg::REG_GRID_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_index <= gcb_pkg::REG_GRID_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_we <= 1'b0;
        width_reg  = w;
        height_reg = h;
        sizes_used++;
    endtask

    task automatic random_phase(input int n, input logic [7:0] w, input logic [7:0] h,
                                input bit quiet, input bit squeeze);
        int         ew;
        int         eh;
        int         fx;
        int         fy;
        logic       cmd;
        logic [6:0] x;
        logic [6:0] y;
        resize_grid(w, h);
        calm = quiet;
        ew = (w > GRID_X) ? GRID_X : w;
        eh = (h > GRID_Y) ? GRID_Y : h;
        fx = 0;
        fy = 0;
        for (int i = 0; i < n; i++) begin
            if (i % 12 == 0) begin
                fx = (ew > 0) ? $urandom_range(ew - 1, 0) : $urandom_range(127, 0);
                fy = (eh > 0) ? $urandom_range(eh - 1, 0) : $urandom_range(127, 0);
            end
            if (squeeze && i == 10)
                hold_asks++;
            cmd = ($urandom_range(99, 0) < 55) ? gcb_pkg::CMD_MARK : gcb_pkg::CMD_CLASSIFY;
            if ($urandom_range(9, 0) < 8) begin
                x = 7'(fx + int'($urandom_range(4, 0)) - 2);
                y = 7'(fy + int'($urandom_range(4, 0)) - 2);
            end else begin
                x = 7'($urandom);
                y = 7'($urandom);
            end
            offer_item(cmd, x, y, 1'b0, '0);
        end
        calm = 1'b0;
    endtask

    // result side: random stalls, plus a long hold-off on request
    initial begin : drive_ready
        int holds_served;
        holds_served = 0;
        m_tready = 1'b0;
        forever begin
            if (hold_asks != holds_served) begin
                holds_served = hold_asks;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(3, 0) == 0) begin
                m_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(12, 1)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        grid_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (m_tdata[2:0] < 5)
                class_seen[m_tdata[2:0]]++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: node_class %0d bad_coordinate %0d solid_total %0d",
                       m_tdata[2:0], m_tuser, m_tdata[17:3]);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_tdata[2:0] !== want.cls) begin
                    $error("node_class: expected %0d, got %0d", want.cls, m_tdata[2:0]);
                    error_count++;
                end
                if (m_tuser !== want.bad) begin
                    $error("bad_coordinate: expected %0d, got %0d", want.bad, m_tuser);
                    error_count++;
                end
                if (m_tdata[17:3] !== want.total) begin
                    $error("solid_total: expected %0d, got %0d", want.total, m_tdata[17:3]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin : main
        plan_row_t row;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = gcb_pkg::REG_GRID_WIDTH;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = gcb_pkg::CMD_MARK;
        solid_tally  = '0;
        width_reg    = gcb_pkg::DIM_RESET;
        height_reg   = gcb_pkg::DIM_RESET;
        calm         = 1'b0;
        hold_asks    = 0;
        quiet_cycles = 0;
        error_count  = 0;

        plan_resize(8'd1, 8'd1);
        plan_check(gcb_pkg::CMD_CLASSIFY, 7'd0, 7'd0, gcb_pkg::CLS_OPEN_PORE, 1'b0, 15'd0);
        plan_check(gcb_pkg::CMD_CLASSIFY, 7'd0, 7'd1, gcb_pkg::CLS_SOLID_INTERIOR, 1'b1, 15'd0);
        plan_check(gcb_pkg::CMD_MARK, 7'd1, 7'd0, gcb_pkg::CLS_SOLID_INTERIOR, 1'b1, 15'd0);
        plan_item(gcb_pkg::CMD_MARK, 7'd0, 7'd0);
        plan_check(gcb_pkg::CMD_CLASSIFY, 7'd0, 7'd0, gcb_pkg::CLS_SOLID_INTERIOR, 1'b0, 15'd1);
        plan_resize(8'd255, 8'd128);
        plan_check(gcb_pkg::CMD_CLASSIFY, 7'd0, 7'd0, gcb_pkg::CLS_SOLID_BOUNDARY, 1'b0, 15'd1);
        plan_check(gcb_pkg::CMD_CLASSIFY, 7'd1, 7'd1, gcb_pkg::CLS_PORE_BOUNDARY, 1'b0, 15'd1);
        plan_item(gcb_pkg::CMD_MARK, 7'd0, 7'd0);
        plan_item(gcb_pkg::CMD_MARK, 7'd126, 7'd0);
        plan_item(gcb_pkg::CMD_MARK, 7'd126, 7'd1);
        plan_item(gcb_pkg::CMD_MARK, 7'd127, 7'd1);
        plan_check(gcb_pkg::CMD_CLASSIFY, 7'd127, 7'd0, gcb_pkg::CLS_ENCLOSED_PORE, 1'b0, 15'd4);
        plan_item(gcb_pkg::CMD_MARK, 7'd127, 7'd0);
        plan_check(gcb_pkg::CMD_CLASSIFY, 7'd127, 7'd0, gcb_pkg::CLS_SOLID_INTERIOR, 1'b0, 15'd5);
        plan_item(gcb_pkg::CMD_CLASSIFY, 7'd126, 7'd1);
        plan_check(gcb_pkg::CMD_CLASSIFY, 7'd127, 7'd127, gcb_pkg::CLS_OPEN_PORE, 1'b0, 15'd5);
        plan_resize(8'd0, 8'd128);
        plan_check(gcb_pkg::CMD_CLASSIFY, 7'd0, 7'd0, gcb_pkg::CLS_SOLID_INTERIOR, 1'b1, 15'd5);
        plan_check(gcb_pkg::CMD_MARK, 7'd127, 7'd127, gcb_pkg::CLS_SOLID_INTERIOR, 1'b1, 15'd5);
        plan_resize(8'd128, 8'd255);
        plan_item(gcb_pkg::CMD_CLASSIFY, 7'd64, 7'd64);
        plan_item(gcb_pkg::CMD_MARK, 7'd127, 7'd127);
        plan_check(gcb_pkg::CMD_CLASSIFY, 7'd127, 7'd127, gcb_pkg::CLS_SOLID_BOUNDARY,
                   1'b0, 15'd6);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            if (row.kind == ROW_RESIZE)
                resize_grid(row.w, row.h);
            else
                offer_item(row.cmd, row.x, row.y, row.typed, row.want);
        end

        random_phase(120, 8'd128, 8'd128, 1'b0, 1'b0);
        random_phase(120, 8'd8,   8'd8,   1'b0, 1'b0);
        random_phase(120, 8'd255, 8'd6,   1'b1, 1'b1);
        random_phase(60,  8'd1,   8'd1,   1'b0, 1'b0);
        random_phase(60,  8'd0,   8'd255, 1'b0, 1'b0);
        random_phase(120, 8'($urandom_range(128, 1)), 8'($urandom_range(128, 1)),
                     1'b0, 1'b0);
        random_phase(120, 8'd16,  8'd16,  1'b1, 1'b0);
        random_phase(100, 8'd3,   8'd128, 1'b0, 1'b0);
        random_phase(140, 8'd128, 8'd128, 1'b0, 1'b0);

        drain_results();

        $display("tb: %0d input transactions, %0d results checked, %0d grid sizes, %0d solid",
                 items_in, results_checked, sizes_used, solid_tally);
        $display("tb: classes interior/boundary/pore-boundary/open/enclosed %0d/%0d/%0d/%0d/%0d",
                 class_seen[0], class_seen[1], class_seen[2], class_seen[3], class_seen[4]);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/gcb_pkg.sv
sv/gcb_col_ram.sv
sv/gcb_seq.sv
sv/grid_cell_boundary_classifier.sv
sv/gcb_checker.sv
verif/tb.sv
